### design/pfe_pkg.sv
`default_nettype none

package pfe_pkg;

  localparam int ENTRIES_DEF    = 768;
  localparam int FADE_STEPS_DEF = 70;

  localparam int IDX_W   = 10;
  localparam int VAL_W   = 8;
  localparam int CMD_W   = 2;
  localparam int FRAC_W  = 16;
  localparam int LEVEL_W = VAL_W + FRAC_W;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = {LEVEL_W{1'b1}};

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD    = 2'd0,
    CMD_ADVANCE = 2'd1,
    CMD_READ    = 2'd2
  } cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [IDX_W-1:0] entry_index;
    logic [VAL_W-1:0] entry_value;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] out_index;
    logic [VAL_W-1:0] out_value;
  } out_item_t;

endpackage

`default_nettype wire

### design/pfe_chan_if.sv
`default_nettype none

interface pfe_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### design/palette_fade_engine_top.sv
`default_nettype none

// Channel   Dir   Payload                                   Transfer
// in_chan   in    command, entry_index, entry_value         valid && ready
// out_chan  out   out_index, out_value                      valid && ready
// cfg       in    cfg_wdata -> fade_in                      cfg_we
//
// Each item passes from transfer to result through the memory read and then the
// update, write-back and output register load.
// Items follow each other one per cycle while the output register does not stall;
// an update to the same entry is forwarded from the write port to the next item.
// A stalled output register holds the item in the update stage and input stalls.
// Reset clears the control flags and sets fade_in; palette memories are not cleared.

module palette_fade_engine_top #(
  parameter int ENTRIES    = pfe_pkg::ENTRIES_DEF,
  parameter int FADE_STEPS = pfe_pkg::FADE_STEPS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      cfg_we,
  input  wire logic      cfg_wdata,
  pfe_chan_if.sink       in_chan,
  pfe_chan_if.source     out_chan
);

  localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int IDX_W   = pfe_pkg::IDX_W;
  localparam int VAL_W   = pfe_pkg::VAL_W;
  localparam int FRAC_W  = pfe_pkg::FRAC_W;
  localparam int LEVEL_W = pfe_pkg::LEVEL_W;
  localparam int QMAX    = ((2 ** VAL_W - 1) * (2 ** FRAC_W)) / FADE_STEPS;
  localparam int Q_W     = $clog2(QMAX + 1);
  localparam int STEP_W  = Q_W + 1;
  localparam int SUM_W   = ((STEP_W > LEVEL_W) ? STEP_W : LEVEL_W) + 2;
  localparam int TBL_N   = 2 ** VAL_W;

  // quotient table: (value << FRAC_W) / FADE_STEPS
  logic [Q_W-1:0] q_tbl [TBL_N];

  for (genvar g = 0; g < TBL_N; g++) begin : g_qtbl
    localparam int QV = (g * (2 ** FRAC_W)) / FADE_STEPS;
    assign q_tbl[g] = Q_W'(QV);
  end

  logic [LEVEL_W-1:0]       lvl_mem [ENTRIES];
  logic signed [STEP_W-1:0] stp_mem [ENTRIES];

  logic                     fade_in_r;
  logic                     s1_valid_r;
  pfe_pkg::in_item_t        s1_item_r;
  logic                     s1_ok_r;
  logic [AW-1:0]            s1_addr_r;
  logic                     fwd_r;
  logic [LEVEL_W-1:0]       fwd_level_r;
  logic signed [STEP_W-1:0] fwd_step_r;
  logic [LEVEL_W-1:0]       lvl_rd_r;
  logic signed [STEP_W-1:0] stp_rd_r;
  logic                     out_valid_r;
  pfe_pkg::out_item_t       out_item_r;

  logic                     in_ready;
  logic                     acc;
  logic                     s1_fire;
  logic                     in_ok;
  logic [AW+IDX_W-1:0]      idx_wide;
  logic [AW-1:0]            in_addr;

  logic [LEVEL_W-1:0]       cur_level;
  logic signed [STEP_W-1:0] cur_step;
  logic [Q_W-1:0]           q_val;
  logic signed [STEP_W-1:0] q_ext;
  logic signed [SUM_W-1:0]  sum;
  logic [LEVEL_W-1:0]       level_nxt;
  logic signed [STEP_W-1:0] step_nxt;
  logic                     wr_en;
  pfe_pkg::out_item_t       out_item_nxt;

  assign idx_wide = {{AW{1'b0}}, in_chan.payload.entry_index};
  assign in_addr  = idx_wide[AW-1:0];
  assign in_ok    = 32'(in_chan.payload.entry_index) < 32'(ENTRIES);

  assign s1_fire  = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_ready = !s1_valid_r || s1_fire;
  assign acc      = in_chan.valid && in_ready;

  assign in_chan.ready    = in_ready;
  assign out_chan.valid   = out_valid_r;
  assign out_chan.payload = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fade_in_r <= 1'b1;
    end else if (cfg_we) begin
      fade_in_r <= cfg_wdata;
    end
  end

  always_comb begin
    cur_level = fwd_r ? fwd_level_r : lvl_rd_r;
    cur_step  = fwd_r ? fwd_step_r  : stp_rd_r;
    q_val     = q_tbl[s1_item_r.entry_value];
    q_ext     = signed'({1'b0, q_val});
    sum       = SUM_W'(signed'({1'b0, cur_level})) + SUM_W'(cur_step);
    level_nxt = cur_level;
    step_nxt  = cur_step;
    wr_en     = 1'b0;
    case (s1_item_r.command)
      pfe_pkg::CMD_LOAD: begin
        wr_en = s1_ok_r;
        if (fade_in_r) begin
          level_nxt = '0;
          step_nxt  = q_ext;
        end else begin
          level_nxt = {s1_item_r.entry_value, {FRAC_W{1'b0}}};
          step_nxt  = -q_ext;
        end
      end
      pfe_pkg::CMD_ADVANCE: begin
        wr_en = s1_ok_r;
        if (sum[SUM_W-1]) begin
          level_nxt = '0;
        end else if (sum > SUM_W'(pfe_pkg::LEVEL_MAX)) begin
          level_nxt = pfe_pkg::LEVEL_MAX;
        end else begin
          level_nxt = sum[LEVEL_W-1:0];
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
    out_item_nxt.out_index = s1_item_r.entry_index;
    out_item_nxt.out_value = s1_ok_r ? level_nxt[LEVEL_W-1:FRAC_W] : '0;
  end

  always_ff @(posedge clk) begin
    if (s1_fire && wr_en) begin
      lvl_mem[s1_addr_r] <= level_nxt;
    end
    if (acc && in_ok) begin
      lvl_rd_r <= lvl_mem[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && wr_en) begin
      stp_mem[s1_addr_r] <= step_nxt;
    end
    if (acc && in_ok) begin
      stp_rd_r <= stp_mem[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_r      <= 1'b0;
    end else if (acc) begin
      s1_valid_r <= 1'b1;
      fwd_r      <= s1_fire && wr_en && (s1_addr_r == in_addr);
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_item_r   <= in_chan.payload;
      s1_ok_r     <= in_ok;
      s1_addr_r   <= in_addr;
      fwd_level_r <= level_nxt;
      fwd_step_r  <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_item_r <= out_item_nxt;
    end
  end

endmodule

`default_nettype wire
